FILE: hdl/ths_pkg.sv
// ----------------------------------------------------------------------------
// ths_pkg
// Shared types, register map and helpers for the threshold histogram stats
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package ths_pkg;

   // sample and statistic widths
   localparam int SAMPLE_W     = 8;
   localparam int NUM_BINS     = 5;
   localparam int COUNT_BITS   = 24;
   localparam int OUT_COUNT_W  = 24;
   localparam int SUM_W        = 32;
   localparam int SUM_WIDE_W   = SUM_W + 1;

   // configuration port geometry
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 5;
   localparam int REG_IDX_W    = 3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_3 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_4 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_EVENT_LEVEL = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DELAY_EN    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_DELAY_LEVEL = 3'd7;

   typedef logic [SAMPLE_W-1:0]    sample_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [OUT_COUNT_W-1:0] out_count_type;
   typedef logic [SUM_W-1:0]       sum_type;

   localparam count_type  COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam sum_type    SUM_MAX   = {SUM_W{1'b1}};
   localparam sample_type SAMPLE_MAX = {SAMPLE_W{1'b1}};

   // reset values of the registers
   localparam sample_type THRESHOLD_0_RST = 8'd95;
   localparam sample_type THRESHOLD_1_RST = 8'd90;
   localparam sample_type THRESHOLD_2_RST = 8'd85;
   localparam sample_type THRESHOLD_3_RST = 8'd80;
   localparam sample_type THRESHOLD_4_RST = 8'd0;
   localparam sample_type EVENT_LEVEL_RST = 8'd90;
   localparam sample_type DELAY_LEVEL_RST = 8'd0;

   // configuration seen by the datapath
   typedef struct packed {
      sample_type [NUM_BINS-1:0] threshold;
      sample_type                event_level;
      logic                      delay_enable;
      sample_type                delay_level;
   } cfg_type;

   // one result transaction
   typedef struct packed {
      logic                         accepted;
      out_count_type                sample_count;
      sample_type                   minimum;
      sample_type                   maximum;
      sum_type                      total;
      out_count_type                dip_events;
      out_count_type [NUM_BINS-1:0] bin_count;
   } stats_type;

   // saturating increment of an event counter
   function automatic count_type sat_inc(input count_type v);
      return (v == COUNT_MAX) ? v : v + count_type'(1);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/ths_req_if.sv
// ----------------------------------------------------------------------------
// ths_req_if
// Sample channel: valid/ready handshake carrying one sensor sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface ths_req_if;
   import ths_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: hdl/ths_rsp_if.sv
// ----------------------------------------------------------------------------
// ths_rsp_if
// Result channel: valid/ready handshake carrying the statistics snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

interface ths_rsp_if;
   import ths_pkg::*;

   logic          valid;
   logic          ready;
   logic          accepted;
   out_count_type sample_count;
   sample_type    minimum;
   sample_type    maximum;
   sum_type       total;
   out_count_type dip_events;
   out_count_type bin_count_0;
   out_count_type bin_count_1;
   out_count_type bin_count_2;
   out_count_type bin_count_3;
   out_count_type bin_count_4;

   modport source (
      output valid, output accepted, output sample_count, output minimum,
      output maximum, output total, output dip_events, output bin_count_0,
      output bin_count_1, output bin_count_2, output bin_count_3,
      output bin_count_4, input ready
   );
   modport sink (
      input valid, input accepted, input sample_count, input minimum,
      input maximum, input total, input dip_events, input bin_count_0,
      input bin_count_1, input bin_count_2, input bin_count_3,
      input bin_count_4, output ready
   );
endinterface

`default_nettype wire

FILE: hdl/ths_csr.sv
// ----------------------------------------------------------------------------
// ths_csr
// APB-style register file holding bin thresholds, dip level and start delay.
// ----------------------------------------------------------------------------
`default_nettype none

module ths_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ths_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ths_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ths_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output ths_pkg::cfg_type                    cfg
);
   import ths_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   reg_idx;
   sample_type             wr_byte;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_byte    = csr_pwdata[SAMPLE_W-1:0];
   assign cfg        = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_THRESHOLD_0: cfg_in.threshold[0] = wr_byte;
            REG_THRESHOLD_1: cfg_in.threshold[1] = wr_byte;
            REG_THRESHOLD_2: cfg_in.threshold[2] = wr_byte;
            REG_THRESHOLD_3: cfg_in.threshold[3] = wr_byte;
            REG_THRESHOLD_4: cfg_in.threshold[4] = wr_byte;
            REG_EVENT_LEVEL: cfg_in.event_level  = wr_byte;
            REG_DELAY_EN:    cfg_in.delay_enable = csr_pwdata[0];
            REG_DELAY_LEVEL: cfg_in.delay_level  = wr_byte;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold[0] <= THRESHOLD_0_RST;
         cfg_ff.threshold[1] <= THRESHOLD_1_RST;
         cfg_ff.threshold[2] <= THRESHOLD_2_RST;
         cfg_ff.threshold[3] <= THRESHOLD_3_RST;
         cfg_ff.threshold[4] <= THRESHOLD_4_RST;
         cfg_ff.event_level  <= EVENT_LEVEL_RST;
         cfg_ff.delay_enable <= 1'b0;
         cfg_ff.delay_level  <= DELAY_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_THRESHOLD_0: csr_prdata = CSR_DATA_W'(cfg_ff.threshold[0]);
         REG_THRESHOLD_1: csr_prdata = CSR_DATA_W'(cfg_ff.threshold[1]);
         REG_THRESHOLD_2: csr_prdata = CSR_DATA_W'(cfg_ff.threshold[2]);
         REG_THRESHOLD_3: csr_prdata = CSR_DATA_W'(cfg_ff.threshold[3]);
         REG_THRESHOLD_4: csr_prdata = CSR_DATA_W'(cfg_ff.threshold[4]);
         REG_EVENT_LEVEL: csr_prdata = CSR_DATA_W'(cfg_ff.event_level);
         REG_DELAY_EN:    csr_prdata = CSR_DATA_W'(cfg_ff.delay_enable);
         REG_DELAY_LEVEL: csr_prdata = CSR_DATA_W'(cfg_ff.delay_level);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/ths_stats.sv
// ----------------------------------------------------------------------------
// ths_stats
// Running statistics state: start delay, count, min, max, sum, dip events
// and cumulative bins, updated once per processed sample.
// ----------------------------------------------------------------------------
`default_nettype none

module ths_stats (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire ths_pkg::sample_type sample,
   input  wire ths_pkg::cfg_type    cfg,
   output ths_pkg::stats_type       result
);
   import ths_pkg::*;

   logic                       waiting_ff, waiting_in;
   logic                       above_ff, above_in;
   count_type                  count_ff, count_in;
   sample_type                 min_ff, min_in;
   sample_type                 max_ff, max_in;
   sum_type                    sum_ff, sum_in;
   count_type                  event_ff, event_in;
   count_type [NUM_BINS-1:0]   bin_ff, bin_in;
   logic                       delay_active;
   logic                       below_delay;
   logic                       accepted_in;
   logic [SUM_WIDE_W-1:0]      sum_wide;

   // start delay gate
   assign delay_active = cfg.delay_enable && waiting_ff;
   assign below_delay  = sample < cfg.delay_level;
   assign accepted_in  = !delay_active || below_delay;
   assign sum_wide     = {1'b0, sum_ff} + SUM_WIDE_W'(sample);

   // next state for one sample
   always_comb begin
      waiting_in = waiting_ff;
      above_in   = above_ff;
      count_in   = count_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      sum_in     = sum_ff;
      event_in   = event_ff;
      bin_in     = bin_ff;
      if (delay_active && below_delay) begin
         waiting_in = 1'b0;
      end
      if (accepted_in) begin
         // dip counting with re-arm above the level
         if (above_ff && (sample < cfg.event_level)) begin
            above_in = 1'b0;
            event_in = sat_inc(event_ff);
         end else if (!above_ff && (sample > cfg.event_level)) begin
            above_in = 1'b1;
         end
         for (int k = 0; k < NUM_BINS; k++) begin
            if (sample < cfg.threshold[k]) begin
               bin_in[k] = sat_inc(bin_ff[k]);
            end
         end
         if (sample < min_ff) begin
            min_in = sample;
         end
         if (sample > max_ff) begin
            max_in = sample;
         end
         sum_in   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
         count_in = sat_inc(count_ff);
      end
   end

   // snapshot after this sample
   always_comb begin
      result.accepted     = accepted_in;
      result.sample_count = OUT_COUNT_W'(count_in);
      result.minimum      = min_in;
      result.maximum      = max_in;
      result.total        = sum_in;
      result.dip_events   = OUT_COUNT_W'(event_in);
      for (int k = 0; k < NUM_BINS; k++) begin
         result.bin_count[k] = OUT_COUNT_W'(bin_in[k]);
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b1;
         above_ff   <= 1'b1;
         count_ff   <= '0;
         min_ff     <= SAMPLE_MAX;
         max_ff     <= '0;
         sum_ff     <= '0;
         event_ff   <= '0;
         bin_ff     <= '0;
      end else if (fire) begin
         waiting_ff <= waiting_in;
         above_ff   <= above_in;
         count_ff   <= count_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         sum_ff     <= sum_in;
         event_ff   <= event_in;
         bin_ff     <= bin_in;
      end
   end

   // a dropped sample leaves the sample count alone
   a_drop_holds_count: assert property (@(posedge clock) disable iff (reset)
      fire && !accepted_in |=> $stable(count_ff))
      else $error("sample count moved on a dropped sample");

   // once anything was counted the minimum cannot exceed the maximum
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> min_ff <= max_ff)
      else $error("minimum above maximum");

   // bin 0 never counts more samples than were accepted
   a_bin_le_count: assert property (@(posedge clock) disable iff (reset)
      bin_ff[0] <= count_ff)
      else $error("bin 0 exceeds sample count");

endmodule

`default_nettype wire

FILE: hdl/threshold_histogram_stats.sv
// ----------------------------------------------------------------------------
// threshold_histogram_stats
// Running min/max/sum/count, cumulative threshold bins and dip event count
// over a stream of 8-bit sensor samples.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one sample per transaction, rsp returns one statistics
//   snapshot per sample (accepted flag plus all statistics after it).
//   The csr_ APB-style port sets the five bin thresholds, the dip level and
//   the start delay; write it only while no sample is in flight.
// Pipeline and throughput:
//   a sample accepted on req is registered in the input stage, folded into
//   the statistics when it advances to the result register and presented on
//   rsp from then on. The input register and the result register form a
//   two-stage pipeline that takes one sample every cycle while rsp is not
//   stalled; the per-sample update is one compare/increment pass.
// Reset:
//   synchronous; clears both pipeline stages, restores register defaults
//   and the statistics to count 0, min 255, max 0, sum 0, start delay armed.
// Stall:
//   when rsp.ready is low the result holds, the input register fills and
//   req.ready drops only once both stages are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_histogram_stats (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ths_req_if.sink                             req,
   ths_rsp_if.source                           rsp,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ths_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ths_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ths_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import ths_pkg::*;

   cfg_type    cfg;
   stats_type  result_in;
   stats_type  result_ff;
   logic       s1_valid_ff, s1_valid_in;
   sample_type s1_sample_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_fire;

   ths_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ths_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .sample (s1_sample_ff),
      .cfg    (cfg),
      .result (result_in)
   );

   // pipeline flow control
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready    = !s1_valid_ff || advance;
   assign req_fire     = req.valid && req.ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff <= req.sample;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   // result channel
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.accepted     = result_ff.accepted;
   assign rsp.sample_count = result_ff.sample_count;
   assign rsp.minimum      = result_ff.minimum;
   assign rsp.maximum      = result_ff.maximum;
   assign rsp.total        = result_ff.total;
   assign rsp.dip_events   = result_ff.dip_events;
   assign rsp.bin_count_0  = result_ff.bin_count[0];
   assign rsp.bin_count_1  = result_ff.bin_count[1];
   assign rsp.bin_count_2  = result_ff.bin_count[2];
   assign rsp.bin_count_3  = result_ff.bin_count[3];
   assign rsp.bin_count_4  = result_ff.bin_count[4];

   // a waiting sample is kept while the result side is stalled
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp.ready
      |=> s1_valid_ff && $stable(s1_sample_ff))
      else $error("input stage lost a sample under stall");

   // every processed sample shows up as a result
   a_advance_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed sample produced no result");

endmodule

`default_nettype wire

FILE: sim/ths_stats_checker.sv
// ----------------------------------------------------------------------------
// ths_stats_checker
// Watches the sample, result and register channels of the threshold histogram
// stats block. It keeps its own copy of the statistics and register settings,
// predicts one snapshot per sample transaction and compares each result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ths_stats_checker (
   input  logic                           clock,
   input  logic                           reset,
   ths_req_if                             req_mon,
   ths_rsp_if                             rsp_mon,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [ths_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ths_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                             mismatch_count,
   output int                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ths_pkg::*;

   // shadow settings and statistics
   cfg_type    shadow_cfg;
   logic       start_armed;
   logic       level_armed;
   count_type  samples_taken;
   count_type  dips_seen;
   count_type  bins_hit [NUM_BINS];
   sample_type lowest;
   sample_type highest;
   sum_type    running_sum;

   stats_type  snapshots_due [$];
   int         results_seen;

   function automatic count_type bump_count(input count_type v);
      if (v == COUNT_MAX)
         return v;
      return v + count_type'(1);
   endfunction

   task automatic clear_shadow();
      shadow_cfg.threshold[0] = THRESHOLD_0_RST;
      shadow_cfg.threshold[1] = THRESHOLD_1_RST;
      shadow_cfg.threshold[2] = THRESHOLD_2_RST;
      shadow_cfg.threshold[3] = THRESHOLD_3_RST;
      shadow_cfg.threshold[4] = THRESHOLD_4_RST;
      shadow_cfg.event_level  = EVENT_LEVEL_RST;
      shadow_cfg.delay_enable = 1'b0;
      shadow_cfg.delay_level  = DELAY_LEVEL_RST;
      start_armed   = 1'b1;
      level_armed   = 1'b1;
      samples_taken = '0;
      dips_seen     = '0;
      foreach (bins_hit[k])
         bins_hit[k] = '0;
      lowest        = SAMPLE_MAX;
      highest       = '0;
      running_sum   = '0;
      snapshots_due.delete();
   endtask

   // fold one sample into the statistics and return the snapshot after it
   task automatic fold_sample(input sample_type s, output stats_type snap);
      logic take;
      take = 1'b1;
      // start delay drops samples until one falls below the delay level
      if (shadow_cfg.delay_enable && start_armed) begin
         if (s < shadow_cfg.delay_level)
            start_armed = 1'b0;
         else
            take = 1'b0;
      end
      if (take) begin
         // dip counting with hysteresis around the event level
         if (level_armed && s < shadow_cfg.event_level) begin
            level_armed = 1'b0;
            dips_seen   = bump_count(dips_seen);
         end else if (!level_armed && s > shadow_cfg.event_level) begin
            level_armed = 1'b1;
         end
         for (int k = 0; k < NUM_BINS; k++)
            if (s < shadow_cfg.threshold[k])
               bins_hit[k] = bump_count(bins_hit[k]);
         if (s < lowest)
            lowest = s;
         if (s > highest)
            highest = s;
         if (SUM_MAX - running_sum >= sum_type'(s))
            running_sum = running_sum + sum_type'(s);
         else
            running_sum = SUM_MAX;
         samples_taken = bump_count(samples_taken);
      end
      snap.accepted     = take;
      snap.sample_count = out_count_type'(samples_taken);
      snap.minimum      = lowest;
      snap.maximum      = highest;
      snap.total        = running_sum;
      snap.dip_events   = out_count_type'(dips_seen);
      for (int k = 0; k < NUM_BINS; k++)
         snap.bin_count[k] = out_count_type'(bins_hit[k]);
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: result %0d: %s", $time, results_seen, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [SUM_W-1:0] got,
                              input logic [SUM_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task automatic check_result();
      stats_type want;
      if (snapshots_due.size() == 0) begin
         report_mismatch("result transaction with no sample outstanding");
         return;
      end
      want = snapshots_due.pop_front();
      check_field("accepted", SUM_W'(rsp_mon.accepted), SUM_W'(want.accepted));
      check_field("sample_count", SUM_W'(rsp_mon.sample_count),
                  SUM_W'(want.sample_count));
      check_field("minimum", SUM_W'(rsp_mon.minimum), SUM_W'(want.minimum));
      check_field("maximum", SUM_W'(rsp_mon.maximum), SUM_W'(want.maximum));
      check_field("total", rsp_mon.total, want.total);
      check_field("dip_events", SUM_W'(rsp_mon.dip_events),
                  SUM_W'(want.dip_events));
      check_field("bin_count_0", SUM_W'(rsp_mon.bin_count_0),
                  SUM_W'(want.bin_count[0]));
      check_field("bin_count_1", SUM_W'(rsp_mon.bin_count_1),
                  SUM_W'(want.bin_count[1]));
      check_field("bin_count_2", SUM_W'(rsp_mon.bin_count_2),
                  SUM_W'(want.bin_count[2]));
      check_field("bin_count_3", SUM_W'(rsp_mon.bin_count_3),
                  SUM_W'(want.bin_count[3]));
      check_field("bin_count_4", SUM_W'(rsp_mon.bin_count_4),
                  SUM_W'(want.bin_count[4]));
   endtask

   // register write as seen on the access cycle
   task automatic apply_csr_write();
      case (csr_paddr[CSR_ADDR_W-1:2])
         REG_THRESHOLD_0: shadow_cfg.threshold[0] = csr_pwdata[SAMPLE_W-1:0];
         REG_THRESHOLD_1: shadow_cfg.threshold[1] = csr_pwdata[SAMPLE_W-1:0];
         REG_THRESHOLD_2: shadow_cfg.threshold[2] = csr_pwdata[SAMPLE_W-1:0];
         REG_THRESHOLD_3: shadow_cfg.threshold[3] = csr_pwdata[SAMPLE_W-1:0];
         REG_THRESHOLD_4: shadow_cfg.threshold[4] = csr_pwdata[SAMPLE_W-1:0];
         REG_EVENT_LEVEL: shadow_cfg.event_level  = csr_pwdata[SAMPLE_W-1:0];
         REG_DELAY_EN:    shadow_cfg.delay_enable = csr_pwdata[0];
         REG_DELAY_LEVEL: shadow_cfg.delay_level  = csr_pwdata[SAMPLE_W-1:0];
         default: ;
      endcase
   endtask

   // results first, then new samples, then register writes
   always @(posedge clock) begin
      stats_type snap;
      if (reset) begin
         clear_shadow();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
            results_seen++;
         end
         if (req_mon.valid && req_mon.ready) begin
            fold_sample(req_mon.sample, snap);
            snapshots_due = {snapshots_due, snap};
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            apply_csr_write();
      end
      pending_count = snapshots_due.size();
   end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the threshold histogram stats block: a directed opening on the
// start delay, dip hysteresis and bin edges, then random samples under several
// register settings and idle/stall mixes. The checker beside the block does
// all prediction and comparison; this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ths_pkg::*;

   localparam int PHASE_ITEMS = 408;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int         idle_pct  = 0;
   int         stall_pct = 0;
   sample_type event_mark = EVENT_LEVEL_RST;
   int         mismatch_count;
   int         pending_count;

   ths_req_if req_bus ();
   ths_rsp_if rsp_bus ();

   threshold_histogram_stats u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ths_stats_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one sample transaction, with random idle cycles ahead of it
   task automatic push_sample(input sample_type value);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // hold off the sender until every result is back and the pipe is empty
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   // setup cycle, access cycle, then release
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // levels lean toward the extremes; upper data bits carry noise
   function automatic logic [CSR_DATA_W-1:0] pick_level();
      int         pick;
      sample_type lvl;
      pick = $urandom_range(99);
      if (pick < 15)
         lvl = '0;
      else if (pick < 30)
         lvl = SAMPLE_MAX;
      else
         lvl = sample_type'($urandom);
      return {24'($urandom), lvl};
   endfunction

   task automatic randomize_config();
      logic [CSR_DATA_W-1:0] value;
      for (int k = 0; k < NUM_BINS; k++)
         csr_write(REG_IDX_W'(int'(REG_THRESHOLD_0) + k), pick_level());
      value = pick_level();
      event_mark = value[SAMPLE_W-1:0];
      csr_write(REG_EVENT_LEVEL, value);
      csr_write(REG_DELAY_EN, {31'($urandom), 1'($urandom)});
      csr_write(REG_DELAY_LEVEL, pick_level());
   endtask

   // half the samples hover around the event level to work the hysteresis
   function automatic sample_type next_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50)
         return sample_type'(int'(event_mark) + int'($urandom_range(6)) - 3);
      if (pick < 60)
         return ($urandom_range(1) != 0) ? SAMPLE_MAX : sample_type'(0);
      return sample_type'($urandom);
   endfunction

   initial begin
      sample_type early_samples [4]  = '{8'd0, 8'd255, 8'd100, 8'd89};
      sample_type delay_samples [16] = '{8'd60, 8'd50, 8'd255, 8'd49, 8'd90,
                                         8'd91, 8'd89, 8'd0, 8'd254, 8'd255,
                                         8'd94, 8'd95, 8'd80, 8'd79, 8'd128,
                                         8'd1};
      int phase_idle  [4] = '{0, 81, 0, 7};
      int phase_stall [4] = '{0, 0, 81, 7};

      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // delay off: every sample counts and the start delay stays armed
      foreach (early_samples[i])
         push_sample(early_samples[i]);
      drain_results();

      // delay switched on late still takes effect; bin edges at 0 and 255
      csr_write(REG_DELAY_EN, 32'd1);
      csr_write(REG_DELAY_LEVEL, 32'd50);
      csr_write(REG_THRESHOLD_4, 32'd255);
      csr_write(REG_THRESHOLD_1, 32'd0);
      foreach (delay_samples[i])
         push_sample(delay_samples[i]);
      drain_results();

      // random phases, each under fresh settings and its own idle and stall mix
      for (int p = 0; p < 4; p++) begin
         randomize_config();
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         repeat (PHASE_ITEMS)
            push_sample(next_sample());
         drain_results();
      end

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4800000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
